// ===== rtl/u8dc_pkg.sv =====
package u8dc_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int LEN_W   = 3;
  localparam int DW_W    = 2;
  localparam int RUN_W   = 16;
  localparam int RAW_MAX = 4;

  localparam int TOTAL_WIDTH_DEFAULT = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // byte classes
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;

  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  localparam logic [DW_W-1:0] WIDTH_ZERO   = 2'd0;
  localparam logic [DW_W-1:0] WIDTH_NARROW = 2'd1;
  localparam logic [DW_W-1:0] WIDTH_WIDE   = 2'd2;

  // one queue entry: either raw bytes flushed one by one, or one decoded character
  typedef struct packed {
    logic [RAW_MAX-1:0][BYTE_W-1:0] raw;
    logic [LEN_W-1:0]               raw_count;
    logic                           decoded;
    logic [CP_W-1:0]                cp;
    logic [LEN_W-1:0]               len;
    logic [DW_W-1:0]                width;
    logic                           ends;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

  function automatic logic in_rng(input logic [CP_W-1:0] cp,
                                  input logic [CP_W-1:0] lo,
                                  input logic [CP_W-1:0] hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  function automatic logic [DW_W-1:0] width_of(input logic [CP_W-1:0] cp);
    logic zero_w;
    logic wide_w;
    zero_w = (cp == '0) ||
             in_rng(cp, 21'h00300, 21'h0036F) || in_rng(cp, 21'h020D0, 21'h020FF) ||
             in_rng(cp, 21'h0FE20, 21'h0FE2F);
    wide_w = in_rng(cp, 21'h01100, 21'h011FF) || in_rng(cp, 21'h02600, 21'h027BF) ||
             in_rng(cp, 21'h02E80, 21'h02EFF) || in_rng(cp, 21'h03000, 21'h033FF) ||
             in_rng(cp, 21'h03400, 21'h04DBF) || in_rng(cp, 21'h04E00, 21'h09FFF) ||
             in_rng(cp, 21'h0A000, 21'h0A4CF) || in_rng(cp, 21'h0AC00, 21'h0D7A3) ||
             in_rng(cp, 21'h0F900, 21'h0FAFF) || in_rng(cp, 21'h0FE10, 21'h0FE1F) ||
             in_rng(cp, 21'h0FE30, 21'h0FE4F) || in_rng(cp, 21'h0FF01, 21'h0FF60) ||
             in_rng(cp, 21'h0FFE0, 21'h0FFE6) || in_rng(cp, 21'h1F000, 21'h1FFFF) ||
             in_rng(cp, 21'h20000, 21'h2FA1F);
    if (zero_w) return WIDTH_ZERO;
    if (wide_w) return WIDTH_WIDE;
    return WIDTH_NARROW;
  endfunction

endpackage

// ===== rtl/u8dc_ifs.sv =====
interface u8dc_in_if;
  import u8dc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              ends_string;

  modport source(output valid, in_byte, ends_string, input ready);
  modport sink(input valid, in_byte, ends_string, output ready);
endinterface

interface u8dc_out_if;
  import u8dc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   code_point;
  logic [LEN_W-1:0]  byte_count;
  logic [DW_W-1:0]   display_width;
  logic [DW_W-1:0]   cells_added;
  logic [RUN_W-1:0]  running_cells;
  logic              last_of_input;
  logic              string_done;

  modport source(output valid, code_point, byte_count, display_width, cells_added,
                 running_cells, last_of_input, string_done, input ready);
  modport sink(input valid, code_point, byte_count, display_width, cells_added,
               running_cells, last_of_input, string_done, output ready);
endinterface

// ===== rtl/u8dc_front.sv =====
module u8dc_front (
  input  logic           clk,
  input  logic           rst,
  u8dc_in_if.sink        in_chan,
  input  logic           queue_full,
  output u8dc_pkg::job_t job,
  output logic           job_push
);
  import u8dc_pkg::*;

  logic [2:0][BYTE_W-1:0] held;
  logic [2:0][BYTE_W-1:0] held_next;
  logic [1:0]             held_count;
  logic [1:0]             held_count_next;
  logic [LEN_W-1:0]       needed_length;
  logic [LEN_W-1:0]       needed_length_next;

  logic [BYTE_W-1:0] b;
  logic              accept;
  logic              pending;
  logic              cont;
  logic [LEN_W-1:0]  lead_len;
  logic [1:0]        raw_base;
  logic              append;
  logic [CP_W-1:0]   cp;

  assign b        = in_chan.in_byte;
  assign in_chan.ready = !queue_full;
  assign accept   = in_chan.valid && !queue_full;
  assign pending  = (needed_length != LEN_NONE);
  assign cont     = ((b & CONT_MASK) == CONT_TAG);
  assign job_push = accept && (job.decoded || (job.raw_count != LEN_NONE));

  always_comb begin
    priority if ((b & LEAD2_MASK) == LEAD2_TAG) lead_len = LEN_TWO;
    else if ((b & LEAD3_MASK) == LEAD3_TAG)     lead_len = LEN_THREE;
    else if ((b & LEAD4_MASK) == LEAD4_TAG)     lead_len = LEN_FOUR;
    else                                        lead_len = LEN_NONE;
  end

  always_comb begin
    unique case (needed_length)
      LEN_TWO:   cp = CP_W'({held[0][4:0], b[5:0]});
      LEN_THREE: cp = CP_W'({held[0][3:0], held[1][5:0], b[5:0]});
      default:   cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
    endcase
  end

  always_comb begin
    held_next          = held;
    held_count_next    = held_count;
    needed_length_next = needed_length;
    raw_base           = 2'd0;
    append             = 1'b0;
    job.decoded        = 1'b0;
    job.cp             = cp;
    job.len            = needed_length;
    job.width          = width_of(cp);
    job.ends           = in_chan.ends_string;

    if (pending && cont) begin
      if ((LEN_W'(held_count) + LEN_ONE) >= needed_length) begin
        job.decoded        = 1'b1;
        held_count_next    = 2'd0;
        needed_length_next = LEN_NONE;
      end else begin
        held_next[held_count] = b;
        held_count_next       = held_count + 2'd1;
        if (in_chan.ends_string) begin
          // flush the sequence, new byte included
          raw_base           = held_count;
          append             = 1'b1;
          held_count_next    = 2'd0;
          needed_length_next = LEN_NONE;
        end
      end
    end else begin
      raw_base = pending ? held_count : 2'd0;
      if ((lead_len == LEN_NONE) || in_chan.ends_string) begin
        append             = 1'b1;
        held_count_next    = 2'd0;
        needed_length_next = LEN_NONE;
      end else begin
        held_next[0]       = b;
        held_count_next    = 2'd1;
        needed_length_next = lead_len;
      end
    end

    for (int i = 0; i < 3; i++) begin
      job.raw[i] = (2'(i) < raw_base) ? held[i] : b;
    end
    job.raw[3]    = b;
    job.raw_count = LEN_W'(raw_base) + LEN_W'(append);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= 2'd0;
      needed_length <= LEN_NONE;
    end else if (accept) begin
      held_count    <= held_count_next;
      needed_length <= needed_length_next;
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (needed_length == LEN_NONE) |-> (held_count == 2'd0))
    else $error("bytes held with no pending sequence");

  a_held_short: assert property (@(posedge clk) disable iff (rst)
    (needed_length != LEN_NONE) |-> (LEN_W'(held_count) < needed_length))
    else $error("held bytes reach sequence length");

endmodule

// ===== rtl/u8dc_queue.sv =====
module u8dc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8dc_pkg::job_t    push_job,
  output logic              full,
  output u8dc_pkg::q_head_t head,
  input  logic              pop
);
  import u8dc_pkg::*;

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW:0]   wr_ptr;
  logic [QUEUE_AW:0]   rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign fill       = wr_ptr - rd_ptr;
  assign full       = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.job   = entries[rd_ptr[QUEUE_AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr[QUEUE_AW-1:0]] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + (QUEUE_AW+1)'(1);
      if (pop)  rd_ptr <= rd_ptr + (QUEUE_AW+1)'(1);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue over capacity");

endmodule

// ===== rtl/u8dc_back.sv =====
module u8dc_back #(
  parameter int TOTAL_WIDTH = u8dc_pkg::TOTAL_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  u8dc_pkg::q_head_t head,
  output logic              pop,
  u8dc_out_if.source        out_chan
);
  import u8dc_pkg::*;

  logic                   out_valid;
  logic [1:0]             idx;
  logic [TOTAL_WIDTH-1:0] total;

  logic                   load;
  logic                   last;
  logic [CP_W-1:0]        r_cp;
  logic [LEN_W-1:0]       r_len;
  logic [DW_W-1:0]        r_width;
  logic [DW_W-1:0]        r_cells;
  logic [TOTAL_WIDTH:0]   sum;
  logic [TOTAL_WIDTH-1:0] sat;
  logic [RUN_W-1:0]       run_view;

  assign load = head.valid && (!out_valid || out_chan.ready);
  assign last = head.job.decoded || ((LEN_W'(idx) + LEN_ONE) == head.job.raw_count);
  assign pop  = load && last;

  always_comb begin
    if (head.job.decoded) begin
      r_cp    = head.job.cp;
      r_len   = head.job.len;
      r_width = head.job.width;
    end else begin
      r_cp    = CP_W'(head.job.raw[idx]);
      r_len   = LEN_ONE;
      r_width = WIDTH_NARROW;
    end
    r_cells = (r_width == WIDTH_ZERO) ? WIDTH_NARROW : r_width;
    sum     = {1'b0, total} + (TOTAL_WIDTH+1)'(r_cells);
    sat     = sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];
  end

  if (TOTAL_WIDTH >= RUN_W) begin : g_run_cut
    assign run_view = sat[RUN_W-1:0];
  end else begin : g_run_ext
    assign run_view = RUN_W'(sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
      total     <= '0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_chan.ready) out_valid <= 1'b0;
      if (pop) idx <= 2'd0;
      else if (load) idx <= idx + 2'd1;
      // clear the total after the string's final character
      if (load) total <= (last && head.job.ends) ? '0 : sat;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_chan.code_point    <= r_cp;
      out_chan.byte_count    <= r_len;
      out_chan.display_width <= r_width;
      out_chan.cells_added   <= r_cells;
      out_chan.running_cells <= run_view;
      out_chan.last_of_input <= last;
      out_chan.string_done   <= last && head.job.ends;
    end
  end

  assign out_chan.valid = out_valid;

  a_idx_rewind: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == 2'd0))
    else $error("beat index not rewound after job");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_chan.string_done) |-> out_chan.last_of_input)
    else $error("string end not on final beat of a byte");

  a_multi_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_chan.byte_count != LEN_ONE)) |-> out_chan.last_of_input)
    else $error("decoded character shares its byte with other beats");

endmodule

// ===== rtl/utf8_display_cell_counter.sv =====
// UTF-8 display cell counter.
// in_chan carries one string byte per beat (in_byte, ends_string); out_chan
// carries one beat per character: code point, byte count, display width,
// cells added, running cell total, and flags for the last beat of a byte and
// of the string. Both channels move a beat when valid and ready are high.
// A byte that completes a character, or is a one-byte character, reaches
// out_chan through the queue and the output register. A byte that breaks a
// pending sequence or ends the string flushes the held bytes as one-byte
// characters, up to four beats for that byte, one per cycle from the output
// stage. Sustained rate is one byte per cycle while each byte yields at most
// one beat; a four-entry queue between the byte decoder and the beat
// sequencer absorbs flushes, and in_chan.ready drops only when it is full.
// When the receiver stalls the output register holds its beat, the queue
// fills, then input stalls. A synchronous reset drops the pending sequence,
// empties the queue, clears the cell total and the output valid.
module utf8_display_cell_counter #(
  parameter int TOTAL_WIDTH = u8dc_pkg::TOTAL_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  u8dc_in_if.sink     in_chan,
  u8dc_out_if.source  out_chan
);
  import u8dc_pkg::*;

  job_t    job;
  logic    job_push;
  logic    queue_full;
  q_head_t head;
  logic    pop;

  u8dc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_chan    (in_chan),
    .queue_full (queue_full),
    .job        (job),
    .job_push   (job_push)
  );

  u8dc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .full     (queue_full),
    .head     (head),
    .pop      (pop)
  );

  u8dc_back #(
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
